@@ rtl/core/ks_pkg.sv @@
package ks_pkg;

   // Port payload widths
   localparam int KEY_W = 16;

   // Input item codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Top-level control sequence
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_FETCH,
      ST_PUSH
   } top_state_type;

   // Heap sort sequencer
   typedef enum logic [2:0] {
      SS_IDLE,
      SS_RD_ROOT,
      SS_RV,
      SS_LC,
      SS_RC,
      SS_CMP,
      SS_EX_RD0,
      SS_EX_SWAP
   } sort_state_type;

   // Key memory port enables
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_en_type;

endpackage

@@ rtl/core/ks_req_if.sv @@
interface ks_req_if import ks_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [KEY_W-1:0] key;

   modport source (output valid, output action, output key, input ready);
   modport sink (input valid, input action, input key, output ready);
endinterface

@@ rtl/core/ks_rsp_if.sv @@
interface ks_rsp_if import ks_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] sorted_key;
   logic             last;
   logic             empty_res;

   modport source (output valid, output sorted_key, output last, output empty_res, input ready);
   modport sink (input valid, input sorted_key, input last, input empty_res, output ready);
endinterface

@@ rtl/core/key_sort_engine.sv @@
// Key sort engine: collects keys and returns them in ascending order.
// req_if carries items: action load appends key to the store (ignored
// when CAPACITY keys are held or while a sorted list is being read out);
// action read returns the next sorted key on rsp_if. The first read after
// loading sorts the store in place with a heap sort run by a sequencer
// around one synchronous key memory (one read and one write per cycle).
// A load writes its key to the memory as it is taken. A read passes the
// fetch and push states; the first read after loading two or more keys
// sorts first: left child read, right child read and compare per level.
// rsp_if marks the final key with last; a read with nothing left answers
// empty_res with sorted_key and last at zero and clears the block for a
// new load. A result waits in the output register while the receiver
// stalls; loads are still taken, and a read finishes its memory work and
// then holds until the output register frees. Reset empties the store,
// drops the output register's valid flag and returns all control to idle.
module key_sort_engine import ks_pkg::*; #(
   parameter int CAPACITY = 128,
   parameter int KEY_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ks_req_if.sink    req_if,
   ks_rsp_if.source  rsp_if
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   top_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    load_count_ff, load_count_in;
   logic [CNT_W-1:0]    read_index_ff, read_index_in;
   logic                is_sorted_ff, is_sorted_in;
   logic                empty_ff, empty_in;
   logic                last_ff, last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic                req_fire, do_load, do_read, need_sort, out_free;
   logic                fetch_empty;

   mem_en_type          sort_en, top_en, mem_en;
   logic [IDX_W-1:0]    sort_rd_addr, sort_wr_addr, top_rd_addr;
   logic [IDX_W-1:0]    mem_rd_addr, mem_wr_addr;
   logic [KEY_BITS-1:0] sort_wr_data, mem_wr_data, mem_rd_data;
   logic                sort_start, sort_done;

   // Handshake
   assign req_if.ready      = (state_ff == ST_IDLE);
   assign req_fire          = req_if.valid && req_if.ready;
   assign do_load           = req_fire && (req_if.action == ACT_LOAD) && !is_sorted_ff
                              && (load_count_ff < CNT_W'(CAPACITY));
   assign do_read           = req_fire && (req_if.action == ACT_READ);
   assign need_sort         = !is_sorted_ff && (load_count_ff >= CNT_W'(2));
   assign sort_start        = do_read && need_sort;
   assign fetch_empty       = !(read_index_ff < load_count_ff);
   assign out_free          = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sorted_key = rsp_key_ff;
   assign rsp_if.last       = rsp_last_ff;
   assign rsp_if.empty_res  = rsp_empty_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (do_read) state_in = need_sort ? ST_SORT : ST_FETCH;
         ST_SORT:  if (sort_done) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_PUSH;
         ST_PUSH:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Counters, memory requests and the output register
   always_comb begin
      load_count_in = load_count_ff;
      read_index_in = read_index_ff;
      is_sorted_in  = is_sorted_ff;
      empty_in      = empty_ff;
      last_in       = last_ff;
      top_en        = '0;
      top_rd_addr   = read_index_ff[IDX_W-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_load) begin
               top_en.wr     = 1'b1;
               load_count_in = load_count_ff + CNT_W'(1);
            end
            if (do_read) begin
               is_sorted_in = 1'b1;
            end
         end
         ST_FETCH: begin
            empty_in  = fetch_empty;
            last_in   = (read_index_ff + CNT_W'(1)) == load_count_ff;
            top_en.rd = !fetch_empty;
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = empty_ff;
               if (empty_ff) begin
                  rsp_key_in    = '0;
                  rsp_last_in   = 1'b0;
                  load_count_in = '0;
                  read_index_in = '0;
                  is_sorted_in  = 1'b0;
               end else begin
                  rsp_key_in    = KEY_W'(mem_rd_data);
                  rsp_last_in   = last_ff;
                  read_index_in = read_index_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Hand the memory to the sorter while it runs
   always_comb begin
      if (state_ff == ST_SORT) begin
         mem_en      = sort_en;
         mem_rd_addr = sort_rd_addr;
         mem_wr_addr = sort_wr_addr;
         mem_wr_data = sort_wr_data;
      end else begin
         mem_en      = top_en;
         mem_rd_addr = top_rd_addr;
         mem_wr_addr = load_count_ff[IDX_W-1:0];
         mem_wr_data = KEY_BITS'(req_if.key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         read_index_ff <= '0;
         is_sorted_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         read_index_ff <= read_index_in;
         is_sorted_ff  <= is_sorted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      empty_ff     <= empty_in;
      last_ff      <= last_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   ks_key_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_BITS)
   ) u_key_ram (
      .clock   (clock),
      .en      (mem_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   ks_heap_sorter #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_heap_sorter (
      .clock   (clock),
      .reset   (reset),
      .start   (sort_start),
      .count   (load_count_ff),
      .done    (sort_done),
      .mem_en  (sort_en),
      .rd_addr (sort_rd_addr),
      .rd_data (mem_rd_data),
      .wr_addr (sort_wr_addr),
      .wr_data (sort_wr_data)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CNT_W'(CAPACITY))
      else $error("load count above capacity");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      read_index_ff <= load_count_ff)
      else $error("read index past load count");

   a_unsorted_index: assert property (@(posedge clock) disable iff (reset)
      !is_sorted_ff |-> read_index_ff == '0)
      else $error("read index nonzero while unsorted");

   a_done_in_sort: assert property (@(posedge clock) disable iff (reset)
      sort_done |-> state_ff == ST_SORT)
      else $error("sorter finished outside sort phase");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_key_ff == '0) && !rsp_last_ff)
      else $error("empty result carries a key");

   a_no_load_sorted: assert property (@(posedge clock) disable iff (reset)
      (is_sorted_ff && state_ff == ST_IDLE) |=> load_count_ff == $past(load_count_ff))
      else $error("key stored during read-out");
`endif

endmodule

@@ rtl/core/ks_key_ram.sv @@
module ks_key_ram import ks_pkg::*; #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  mem_en_type       en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old entry when the same address is written
   always_ff @(posedge clock) begin
      if (en.rd) begin
         rd_data <= mem[rd_addr];
      end
      if (en.wr) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

@@ rtl/core/ks_heap_sorter.sv @@
module ks_heap_sorter import ks_pkg::*; #(
   parameter int CAPACITY = 128,
   parameter int KEY_BITS = 16,
   localparam int IDX_W   = $clog2(CAPACITY),
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CNT_W-1:0]    count,
   output logic                done,
   output mem_en_type          mem_en,
   output logic [IDX_W-1:0]    rd_addr,
   input  logic [KEY_BITS-1:0] rd_data,
   output logic [IDX_W-1:0]    wr_addr,
   output logic [KEY_BITS-1:0] wr_data
);

   localparam int CW = IDX_W + 2;

   sort_state_type      state_ff, state_in;
   logic                extract_ff, extract_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    root_ff, root_in;
   logic [CNT_W-1:0]    size_ff, size_in;
   logic [KEY_BITS-1:0] rv_ff, rv_in;
   logic [KEY_BITS-1:0] lv_ff, lv_in;

   logic [CW-1:0]       lc_idx, rc_idx, size_ext;
   logic                has_lc, has_rc;
   logic                lc_gt, rc_win, move;
   logic [KEY_BITS-1:0] big_val;
   logic                sift_end;
   sort_state_type      after_sift;

   // Child positions of the current hole
   assign lc_idx   = {1'b0, root_ff, 1'b1};
   assign rc_idx   = lc_idx + CW'(1);
   assign size_ext = CW'(size_ff);
   assign has_lc   = lc_idx < size_ext;
   assign has_rc   = rc_idx < size_ext;

   // Pick the largest of the sifting key and its children
   assign lc_gt   = lv_ff > rv_ff;
   assign big_val = lc_gt ? lv_ff : rv_ff;
   assign rc_win  = has_rc && (rd_data > big_val);
   assign move    = lc_gt || rc_win;

   assign sift_end = ((state_ff == SS_LC) && !has_lc) || ((state_ff == SS_CMP) && !move);

   // Task that follows a finished sift
   always_comb begin
      if (!extract_ff) begin
         after_sift = (cnt_ff == '0) ? SS_EX_RD0 : SS_RD_ROOT;
      end else begin
         after_sift = (cnt_ff == IDX_W'(1)) ? SS_IDLE : SS_EX_RD0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SS_IDLE:    if (start) state_in = SS_RD_ROOT;
         SS_RD_ROOT: state_in = SS_RV;
         SS_RV:      state_in = SS_LC;
         SS_LC:      state_in = has_lc ? SS_RC : after_sift;
         SS_RC:      state_in = SS_CMP;
         SS_CMP:     state_in = move ? SS_LC : after_sift;
         SS_EX_RD0:  state_in = SS_EX_SWAP;
         SS_EX_SWAP: state_in = SS_RV;
         default:    state_in = SS_IDLE;
      endcase
   end

   // Memory accesses and counters
   always_comb begin
      extract_in = extract_ff;
      cnt_in     = cnt_ff;
      root_in    = root_ff;
      size_in    = size_ff;
      rv_in      = rv_ff;
      lv_in      = lv_ff;
      mem_en     = '0;
      rd_addr    = root_ff;
      wr_addr    = root_ff;
      wr_data    = rv_ff;
      done       = 1'b0;
      case (state_ff)
         SS_IDLE: begin
            if (start) begin
               extract_in = 1'b0;
               size_in    = count;
               cnt_in     = IDX_W'((count >> 1) - CNT_W'(1));
               root_in    = IDX_W'((count >> 1) - CNT_W'(1));
            end
         end
         SS_RD_ROOT: begin
            mem_en.rd = 1'b1;
         end
         SS_RV: begin
            rv_in = rd_data;
         end
         SS_LC: begin
            if (has_lc) begin
               mem_en.rd = 1'b1;
               rd_addr   = lc_idx[IDX_W-1:0];
            end
         end
         SS_RC: begin
            lv_in = rd_data;
            if (has_rc) begin
               mem_en.rd = 1'b1;
               rd_addr   = rc_idx[IDX_W-1:0];
            end
         end
         SS_CMP: begin
            if (move) begin
               // Move the larger child up into the hole
               mem_en.wr = 1'b1;
               wr_data   = rc_win ? rd_data : lv_ff;
               root_in   = rc_win ? rc_idx[IDX_W-1:0] : lc_idx[IDX_W-1:0];
            end
         end
         SS_EX_RD0: begin
            mem_en.rd = 1'b1;
            rd_addr   = '0;
         end
         SS_EX_SWAP: begin
            // Park the maximum at the end, pick up the displaced key
            mem_en.rd = 1'b1;
            mem_en.wr = 1'b1;
            rd_addr   = cnt_ff;
            wr_addr   = cnt_ff;
            wr_data   = rd_data;
            root_in   = '0;
            size_in   = CNT_W'(cnt_ff);
         end
         default: begin
         end
      endcase

      // Drop the sifting key into its final place, then advance
      if (sift_end) begin
         mem_en.wr = 1'b1;
         wr_addr   = root_ff;
         wr_data   = rv_ff;
         if (!extract_ff) begin
            if (cnt_ff == '0) begin
               extract_in = 1'b1;
               cnt_in     = IDX_W'(size_ff - CNT_W'(1));
            end else begin
               cnt_in  = cnt_ff - IDX_W'(1);
               root_in = cnt_ff - IDX_W'(1);
            end
         end else begin
            if (cnt_ff == IDX_W'(1)) begin
               done = 1'b1;
            end else begin
               cnt_in = cnt_ff - IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      extract_ff <= extract_in;
      cnt_ff     <= cnt_in;
      root_ff    <= root_in;
      size_ff    <= size_in;
      rv_ff      <= rv_in;
      lv_ff      <= lv_in;
   end

endmodule
